/* src/wsfd_pkg.sv */
// Package for the WebSocket frame deframer: parse phases, header constants,
// and the structs passed between the input stage, the parser and the output stage.
// No dependencies.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  // 7-bit length code that selects the 16-bit extended length field; the code above it selects the 64-bit field
  localparam logic [6:0] LenExt16 = 7'd126;

  // number of extended length bytes for each form
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        fin;
    logic        rsv1;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  pbyte;
    logic        last;
  } result_t;

endpackage

/* src/wsfd_in_reg.sv */
// Input register stage of the WebSocket frame deframer.
// Holds one accepted byte until the parser consumes it. Uses wsfd_pkg.
module wsfd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               adv_i,
  output wsfd_pkg::in_item_t item_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  // stall only when a byte is held and the parser cannot take it this cycle
  assign in_stall_o = valid_q && !adv_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_byte_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

/* src/wsfd_parser.sv */
// Frame parser of the WebSocket frame deframer: phase state, header fields,
// extended length, masking key and payload count, plus per-byte result logic.
// Uses wsfd_pkg.
module wsfd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsfd_pkg::in_item_t item_i,
  input  logic               adv_i,
  output wsfd_pkg::result_t  res_o
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic        rsv1_q, rsv1_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [63:0] rem_q, rem_d;
  logic        fire;
  logic        len_done;
  logic        emit_hdr;
  logic [7:0]  b;
  logic [7:0]  kb;

  assign fire = item_i.valid && adv_i;
  assign b    = item_i.data;
  // key byte 0 sits in the top byte of the key register
  assign kb   = masked_q ? key_q[{~key_idx_q, 3'b000} +: 8] : 8'd0;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    rsv1_d    = rsv1_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    ext_cnt_d = ext_cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    key_idx_d = key_idx_q;
    rem_d     = rem_q;
    len_done  = 1'b0;
    emit_hdr  = 1'b0;
    res_o     = '0;

    if (fire) begin
      case (phase_q)
        wsfd_pkg::PH_HDR1: begin
          masked_d  = b[7];
          key_idx_d = 2'd0;
          if (b[6:0] < wsfd_pkg::LenExt16) begin
            len_d    = {57'd0, b[6:0]};
            len_done = 1'b1;
          end else begin
            len_d     = '0;
            ext_cnt_d = (b[6:0] == wsfd_pkg::LenExt16) ? wsfd_pkg::ExtBytes16
                                                       : wsfd_pkg::ExtBytes64;
            phase_d   = wsfd_pkg::PH_EXT;
          end
        end
        wsfd_pkg::PH_EXT: begin
          len_d     = {len_q[55:0], b};
          ext_cnt_d = ext_cnt_q - 4'd1;
          len_done  = (ext_cnt_d == 4'd0);
        end
        wsfd_pkg::PH_KEY: begin
          key_d     = {key_q[23:0], b};
          key_idx_d = key_idx_q + 2'd1;
          emit_hdr  = (key_idx_d == 2'd0);
        end
        wsfd_pkg::PH_PAY: begin
          key_idx_d    = key_idx_q + 2'd1;
          rem_d        = rem_q - 64'd1;
          res_o.valid  = 1'b1;
          res_o.kind   = wsfd_pkg::KindPayload;
          res_o.pbyte  = b ^ kb;
          res_o.last   = (rem_d == 64'd0);
          if (rem_d == 64'd0) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end
        end
        default: begin
          fin_d    = b[7];
          rsv1_d   = b[6];
          opcode_d = b[3:0];
          masked_d = 1'b0;
          phase_d  = wsfd_pkg::PH_HDR1;
        end
      endcase

      // masked frames collect the key before the header goes out
      if (len_done) begin
        if (masked_d) begin
          key_d     = '0;
          key_idx_d = 2'd0;
          phase_d   = wsfd_pkg::PH_KEY;
        end else begin
          emit_hdr = 1'b1;
        end
      end

      if (emit_hdr) begin
        key_idx_d   = 2'd0;
        res_o.valid = 1'b1;
        res_o.kind  = wsfd_pkg::KindHeader;
        res_o.pbyte = 8'd0;
        if (len_d == 64'd0) begin
          res_o.last = 1'b1;
          phase_d    = wsfd_pkg::PH_HDR0;
        end else begin
          res_o.last = 1'b0;
          rem_d      = len_d;
          phase_d    = wsfd_pkg::PH_PAY;
        end
      end
    end

    res_o.fin    = fin_d;
    res_o.rsv1   = rsv1_d;
    res_o.opcode = opcode_d;
    res_o.masked = masked_d;
    res_o.length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsfd_pkg::PH_HDR0;
      fin_q     <= 1'b0;
      rsv1_q    <= 1'b0;
      opcode_q  <= 4'd0;
      masked_q  <= 1'b0;
      ext_cnt_q <= 4'd0;
      len_q     <= '0;
      key_q     <= '0;
      key_idx_q <= 2'd0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      rsv1_q    <= rsv1_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      ext_cnt_q <= ext_cnt_d;
      len_q     <= len_d;
      key_q     <= key_d;
      key_idx_q <= key_idx_d;
      rem_q     <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfd_pkg::PH_PAY |-> rem_q != 64'd0)
    else $error("payload phase with no bytes remaining");

  a_pay_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == wsfd_pkg::PH_PAY |-> res_o.valid && res_o.kind)
    else $error("payload byte gave no payload result");

  a_empty_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.kind |-> res_o.last == (res_o.length == 64'd0))
    else $error("header last flag disagrees with payload length");

  a_ext_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfd_pkg::PH_EXT |-> ext_cnt_q != 4'd0 && ext_cnt_q <= wsfd_pkg::ExtBytes64)
    else $error("extended length count out of range");
`endif

endmodule

/* src/wsfd_out_reg.sv */
// Result register of the WebSocket frame deframer.
// Holds one result until the receiver takes it. Uses wsfd_pkg.
module wsfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsfd_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              adv_o,
  output wsfd_pkg::result_t res_o
);

  logic              valid_q;
  logic              valid_d;
  wsfd_pkg::result_t data_q;

  // load when empty or when the held transaction leaves this cycle
  assign adv_o   = !valid_q || !out_stall_i;
  assign valid_d = adv_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_i.valid) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule

/* src/websocket_frame_deframer_top.sv */
// WebSocket frame deframer, top level.
// Input channel: one stream byte per transaction on in_byte_i (in_valid_i / in_stall_o).
// Frames follow each other with no gap: header byte zero, header byte one,
// an optional 2- or 8-byte big-endian length, an optional 4-byte masking key,
// then the payload.
// Output channel: one header result per frame (kind_o = 0) on the byte that
// completes the header, then one result per payload byte (kind_o = 1), unmasked
// when the frame is masked. last_of_frame_o marks the final result of a frame;
// a zero-length frame ends on its header result.
// Throughput: one byte per cycle while the receiver does not stall, set by the single
// parse pass between the input register and the result register.
// A byte accepted into the input register is parsed combinationally and its result
// is loaded into the result register, from which the receiver takes it.
// While the receiver stalls, the result register holds its transaction and one
// more byte is still taken into the input register; after that in_stall_o
// rises until the result leaves.
// Reset (rst_ni low) empties both registers and returns the parser to
// expect header byte zero of a new frame.
// Uses wsfd_pkg, wsfd_in_reg, wsfd_parser and wsfd_out_reg.
module websocket_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        fin_o,
  output logic        rsv1_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_o,
  output logic [63:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o
);

  wsfd_pkg::in_item_t item;
  wsfd_pkg::result_t  res;
  wsfd_pkg::result_t  out_res;
  logic               adv;

  wsfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .adv_i      (adv),
    .item_o     (item)
  );

  wsfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .adv_i  (adv),
    .res_o  (res)
  );

  wsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .res_o       (out_res)
  );

  assign out_valid_o      = out_res.valid;
  assign kind_o           = out_res.kind;
  assign fin_o            = out_res.fin;
  assign rsv1_o           = out_res.rsv1;
  assign frame_opcode_o   = out_res.opcode;
  assign masked_o         = out_res.masked;
  assign payload_length_o = out_res.length;
  assign payload_byte_o   = out_res.pbyte;
  assign last_of_frame_o  = out_res.last;

endmodule

/* tb/wsfd_stream_checker.sv */
// Checker for the WebSocket frame deframer: watches both channels, decodes the
// accepted byte stream on its own and compares every result transaction.
// Depends on wsfd_pkg for the parse phases, length codes and result struct.
module wsfd_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic        fin_i,
  input  logic        rsv1_i,
  input  logic [3:0]  frame_opcode_i,
  input  logic        masked_i,
  input  logic [63:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        last_of_frame_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  phase_e      phase;
  logic        hdr_fin;
  logic        hdr_rsv1;
  logic [3:0]  hdr_opcode;
  logic        hdr_masked;
  logic [3:0]  ext_left;
  logic [63:0] frame_len;
  logic [31:0] mask_key;
  logic [1:0]  key_pos;
  logic [63:0] pay_left;

  result_t deframed_q[$];
  result_t oldest;
  int      fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic push_result(input logic kind, input logic [7:0] pbyte, input logic last);
    result_t r;
    r.valid  = 1'b1;
    r.kind   = kind;
    r.fin    = hdr_fin;
    r.rsv1   = hdr_rsv1;
    r.opcode = hdr_opcode;
    r.masked = hdr_masked;
    r.length = frame_len;
    r.pbyte  = pbyte;
    r.last   = last;
    deframed_q.push_back(r);
  endtask

  task automatic finish_header();
    key_pos = '0;
    if (frame_len == '0) begin
      push_result(KindHeader, 8'h00, 1'b1);
      phase = PH_HDR0;
    end else begin
      push_result(KindHeader, 8'h00, 1'b0);
      pay_left = frame_len;
      phase    = PH_PAY;
    end
  endtask

  task automatic length_complete();
    if (hdr_masked) begin
      mask_key = '0;
      key_pos  = '0;
      phase    = PH_KEY;
    end else begin
      finish_header();
    end
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    logic [31:0] key_shifted;
    logic [7:0]  key_byte;
    case (phase)
      PH_HDR1: begin
        hdr_masked = b[7];
        key_pos    = '0;
        if (b[6:0] < LenExt16) begin
          frame_len = 64'(b[6:0]);
          length_complete();
        end else begin
          frame_len = '0;
          ext_left  = (b[6:0] == LenExt16) ? ExtBytes16 : ExtBytes64;
          phase     = PH_EXT;
        end
      end
      PH_EXT: begin
        frame_len = {frame_len[55:0], b};
        ext_left  = ext_left - 4'd1;
        if (ext_left == '0) length_complete();
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        key_pos  = key_pos + 2'd1;
        if (key_pos == '0) finish_header();
      end
      PH_PAY: begin
        key_shifted = mask_key << {key_pos, 3'b000};
        key_byte    = hdr_masked ? key_shifted[31:24] : 8'h00;
        key_pos     = key_pos + 2'd1;
        pay_left    = pay_left - 64'd1;
        push_result(KindPayload, b ^ key_byte, pay_left == '0);
        if (pay_left == '0) phase = PH_HDR0;
      end
      default: begin
        // RSV2 and RSV3 are dropped; the mask bit clears until byte one
        hdr_fin    = b[7];
        hdr_rsv1   = b[6];
        hdr_opcode = b[3:0];
        hdr_masked = 1'b0;
        phase      = PH_HDR1;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = PH_HDR0;
      hdr_fin    = 1'b0;
      hdr_rsv1   = 1'b0;
      hdr_opcode = '0;
      hdr_masked = 1'b0;
      ext_left   = '0;
      frame_len  = '0;
      mask_key   = '0;
      key_pos    = '0;
      pay_left   = '0;
      deframed_q.delete();
    end else begin
      // check the result first: a byte taken at this edge cannot show up yet
      if (out_valid_i && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          $error("result transaction with none expected: kind %0d byte 0x%0h",
                 kind_i, payload_byte_i);
          fails++;
        end else begin
          oldest = deframed_q.pop_front();
          compare_field("kind", 64'(oldest.kind), 64'(kind_i));
          compare_field("fin", 64'(oldest.fin), 64'(fin_i));
          compare_field("rsv1", 64'(oldest.rsv1), 64'(rsv1_i));
          compare_field("frame_opcode", 64'(oldest.opcode), 64'(frame_opcode_i));
          compare_field("masked", 64'(oldest.masked), 64'(masked_i));
          compare_field("payload_length", oldest.length, payload_length_i);
          compare_field("payload_byte", 64'(oldest.pbyte), 64'(payload_byte_i));
          compare_field("last_of_frame", 64'(oldest.last), 64'(last_of_frame_i));
        end
      end
      if (in_valid_i && !in_stall_i) decode_stream_byte(in_byte_i);
    end
    fail_count_o = fails;
    pending_o    = deframed_q.size();
  end

endmodule

/* tb/websocket_frame_deframer_top_tb.sv */
// Testbench top for websocket_frame_deframer_top: builds directed and random
// WebSocket frame streams, drives stall on the result side and gives the verdict.
// Depends on wsfd_pkg, the deframer RTL and wsfd_stream_checker.
module websocket_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  localparam logic [6:0] LenExt64   = 7'd127;
  localparam int         TargetBytes = 1150;
  localparam int         IdleLimit  = 3000;
  localparam int         LongHold   = 200;

  typedef enum int {FormShort, FormExt16, FormExt64} len_form_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic        fin;
  logic        rsv1;
  logic [3:0]  frame_opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  int fail_total;
  int pending_results;
  int bytes_sent = 0;
  int idle_cycles = 0;
  bit gapless_frame = 1'b0;
  bit long_hold_req = 1'b0;

  websocket_frame_deframer_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_byte_i        (in_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .fin_o            (fin),
    .rsv1_o           (rsv1),
    .frame_opcode_o   (frame_opcode),
    .masked_o         (masked),
    .payload_length_o (payload_length),
    .payload_byte_o   (payload_byte),
    .last_of_frame_o  (last_of_frame)
  );

  wsfd_stream_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_byte_i        (in_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (kind),
    .fin_i            (fin),
    .rsv1_i           (rsv1),
    .frame_opcode_i   (frame_opcode),
    .masked_i         (masked),
    .payload_length_i (payload_length),
    .payload_byte_i   (payload_byte),
    .last_of_frame_i  (last_of_frame),
    .fail_count_o     (fail_total),
    .pending_o        (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    gap = gapless_frame ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic mask, input len_form_e form,
                            input logic [63:0] len, input int n_pay);
    send_byte(hdr0);
    case (form)
      FormShort: send_byte({mask, len[6:0]});
      FormExt16: begin
        send_byte({mask, LenExt16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, LenExt64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (n_pay) send_byte(8'($urandom_range(0, 255)));
  endtask

  // hold off the sender until every expected result has left the block
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic random_frame(input int idx);
    len_form_e   form;
    logic [63:0] len;
    logic [7:0]  hdr0;
    int          r;
    hdr0 = {4'($urandom_range(0, 15)), 4'(idx % 16)};
    r = $urandom_range(0, 99);
    if (r < 60) begin
      form = FormShort;
      len  = ($urandom_range(0, 99) < 4) ? 64'($urandom_range(100, 125))
                                         : 64'($urandom_range(0, 12));
    end else if (r < 85) begin
      form = FormExt16;
      len  = 64'($urandom_range(0, 20));
    end else begin
      form = FormExt64;
      len  = 64'($urandom_range(0, 20));
    end
    gapless_frame = ($urandom_range(0, 99) < 30);
    send_frame(hdr0, 1'($urandom_range(0, 1)), form, len, int'(len));
  endtask

  // result side: stall patterns, quiet stretches and one long hold-off
  initial begin
    int r;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        for (int i = 1; i < LongHold; i++) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          repeat ($urandom_range(20, 100)) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end else begin
          repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40)) begin
            @(negedge clk);
            out_stall <= 1'b1;
          end
          repeat ($urandom_range(1, 4)) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end
      end
    end
  end

  // end the run when no transaction moves on either channel for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("websocket_frame_deframer_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int frame_idx;
    int long_len;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: all-low zero-length frame, all header bits set with a masked
    // zero-length body, non-minimal 16-bit length, zero length in 64-bit form
    gapless_frame = 1'b1;
    send_frame(8'h00, 1'b0, FormShort, 64'd0, 0);
    send_frame(8'hFF, 1'b1, FormShort, 64'd0, 0);
    send_frame(8'h81, 1'b0, FormExt16, 64'd1, 1);
    send_frame(8'h02, 1'b0, FormExt64, 64'd0, 0);
    drain_results();

    frame_idx = 0;
    while (bytes_sent < TargetBytes) begin
      if (frame_idx == 30) begin
        // fill the block behind a long receiver hold-off on a long frame
        long_hold_req = 1'b1;
        gapless_frame = 1'b1;
        long_len      = int'($urandom_range(256, 300));
        send_frame(8'($urandom_range(0, 255)), 1'b1, FormExt16,
                   64'(long_len), long_len);
      end else begin
        random_frame(frame_idx);
      end
      if (frame_idx % 25 == 24) drain_results();
      frame_idx++;
    end

    // huge length with the top bit set: leave the stream inside its payload
    send_frame(8'($urandom_range(0, 255)), 1'b1, FormExt64, 64'hFFFF_FFFF_FFFF_FFFF, 20);

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_total == 0) begin
      $display("websocket_frame_deframer_top_tb: clean");
    end else begin
      $display("websocket_frame_deframer_top_tb: errors");
    end
    $finish;
  end

endmodule
